### sv/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared types and constants for the quaternion vector rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package qrv_pkg;

	localparam int QRV_VEC_WIDTH  = 16;
	localparam int QRV_QUAT_WIDTH = 16;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_SAT  = 2'd1;
	localparam status_t ST_ZERO = 2'd2;

	// Control bits that travel with each word down the pipeline.
	typedef struct packed {
		logic vld;
		logic zero;
	} ctrl_t;

endpackage

`default_nettype wire

### sv/qrv_quat_mul.sv
// ----------------------------------------------------------------------------
// qrv_quat_mul
// Front of the pipeline: both Hamilton products, the squared norm and the
// preparation of the rounded division operands.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_quat_mul #(
	parameter int VW = 16,
	parameter int QW = 16,
	parameter int RW = 2*QW+VW+3,
	parameter int NW = RW+1,
	parameter int DW = 2*QW+1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic signed [VW-1:0]        vx_i,
	input  logic signed [VW-1:0]        vy_i,
	input  logic signed [VW-1:0]        vz_i,
	input  logic signed [QW-1:0]        qw_i,
	input  logic signed [QW-1:0]        qx_i,
	input  logic signed [QW-1:0]        qy_i,
	input  logic signed [QW-1:0]        qz_i,
	output qrv_pkg::ctrl_t              ctrl_o,
	output logic [2:0][NW-1:0]          num_o,
	output logic [2:0]                  neg_o,
	output logic [DW:0]                 den_o
);
	import qrv_pkg::*;

	localparam int PW = QW+VW;
	localparam int TW = QW+VW+2;
	localparam int MW = TW+QW;
	localparam int SW = 2*QW;

	logic [5:1] vld_s;

	// Stage 1: registered inputs.
	logic signed [VW-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [QW-1:0] qw_s1, qx_s1, qy_s1, qz_s1;

	// Stage 2: first products and squares.
	logic signed [PW-1:0] p_s2 [12];
	logic signed [SW-1:0] sq_s2 [4];
	logic signed [QW-1:0] qw_s2, qx_s2, qy_s2, qz_s2;

	// Stage 3: t = q * (0, v) and the squared norm.
	logic signed [TW-1:0] t0_s3, t1_s3, t2_s3, t3_s3;
	logic [DW-1:0]        d_s3;
	logic signed [QW-1:0] qw_s3, qx_s3, qy_s3, qz_s3;

	// Stage 4: second products.
	logic signed [MW-1:0] m_s4 [12];
	logic [DW-1:0]        d_s4;

	// Stage 5: r = t * conj(q), vector part only.
	logic signed [RW-1:0] r_s5 [3];
	logic [DW-1:0]        d_s5;

	logic [RW-1:0] mag [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			ctrl_o <= '0;
		end else if (en) begin
			vld_s       <= {vld_s[4:1], vld_i};
			ctrl_o.vld  <= vld_s[5];
			ctrl_o.zero <= (d_s5 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= vx_i;
			vy_s1 <= vy_i;
			vz_s1 <= vz_i;
			qw_s1 <= qw_i;
			qx_s1 <= qx_i;
			qy_s1 <= qy_i;
			qz_s1 <= qz_i;

			p_s2[0] <= qx_s1 * vx_s1;
			p_s2[1] <= qy_s1 * vy_s1;
			p_s2[2] <= qz_s1 * vz_s1;
			p_s2[3] <= qw_s1 * vx_s1;
			p_s2[4] <= qy_s1 * vz_s1;
			p_s2[5] <= qz_s1 * vy_s1;
			p_s2[6] <= qw_s1 * vy_s1;
			p_s2[7] <= qz_s1 * vx_s1;
			p_s2[8] <= qx_s1 * vz_s1;
			p_s2[9] <= qw_s1 * vz_s1;
			p_s2[10] <= qx_s1 * vy_s1;
			p_s2[11] <= qy_s1 * vx_s1;
			sq_s2[0] <= qw_s1 * qw_s1;
			sq_s2[1] <= qx_s1 * qx_s1;
			sq_s2[2] <= qy_s1 * qy_s1;
			sq_s2[3] <= qz_s1 * qz_s1;
			qw_s2 <= qw_s1;
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
			qz_s2 <= qz_s1;

			t0_s3 <= -(TW'(p_s2[0]) + TW'(p_s2[1]) + TW'(p_s2[2]));
			t1_s3 <= TW'(p_s2[3]) + TW'(p_s2[4]) - TW'(p_s2[5]);
			t2_s3 <= TW'(p_s2[6]) + TW'(p_s2[7]) - TW'(p_s2[8]);
			// t3 = w*vz + x*vy - y*vx
			t3_s3 <= TW'(p_s2[9]) + TW'(p_s2[10]) - TW'(p_s2[11]);
			d_s3  <= DW'($unsigned(sq_s2[0])) + DW'($unsigned(sq_s2[1]))
			       + DW'($unsigned(sq_s2[2])) + DW'($unsigned(sq_s2[3]));
			qw_s3 <= qw_s2;
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
			qz_s3 <= qz_s2;

			m_s4[0]  <= t0_s3 * qx_s3;
			m_s4[1]  <= t1_s3 * qw_s3;
			m_s4[2]  <= t2_s3 * qz_s3;
			m_s4[3]  <= t3_s3 * qy_s3;
			m_s4[4]  <= t0_s3 * qy_s3;
			m_s4[5]  <= t2_s3 * qw_s3;
			m_s4[6]  <= t3_s3 * qx_s3;
			m_s4[7]  <= t1_s3 * qz_s3;
			m_s4[8]  <= t0_s3 * qz_s3;
			m_s4[9]  <= t3_s3 * qw_s3;
			m_s4[10] <= t1_s3 * qy_s3;
			m_s4[11] <= t2_s3 * qx_s3;
			d_s4     <= d_s3;

			r_s5[0] <= -RW'(m_s4[0]) + RW'(m_s4[1]) - RW'(m_s4[2]) + RW'(m_s4[3]);
			r_s5[1] <= -RW'(m_s4[4]) + RW'(m_s4[5]) - RW'(m_s4[6]) + RW'(m_s4[7]);
			r_s5[2] <= -RW'(m_s4[8]) + RW'(m_s4[9]) - RW'(m_s4[10]) + RW'(m_s4[11]);
			d_s5    <= d_s4;

			for (int c = 0; c < 3; c++) begin
				neg_o[c] <= r_s5[c][RW-1];
				num_o[c] <= {mag[c], 1'b0} + NW'(d_s5);
			end
			den_o <= {d_s5, 1'b0};
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag[c] = r_s5[c][RW-1] ? RW'(-r_s5[c]) : RW'(r_s5[c]);
		end
	end

endmodule

`default_nettype wire

### sv/qrv_div_step.sv
// ----------------------------------------------------------------------------
// qrv_div_step
// One restoring division step for the three components, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_div_step #(
	parameter int NW    = 52,
	parameter int DW    = 33,
	parameter int QB    = 17,
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  qrv_pkg::ctrl_t     ctrl_i,
	input  logic [DW:0]        den_i,
	input  logic [2:0][NW-1:0] rem_i,
	input  logic [2:0][QB-1:0] quo_i,
	input  logic [2:0]         neg_i,
	output qrv_pkg::ctrl_t     ctrl_o,
	output logic [DW:0]        den_o,
	output logic [2:0][NW-1:0] rem_o,
	output logic [2:0][QB-1:0] quo_o,
	output logic [2:0]         neg_o
);
	import qrv_pkg::*;

	logic [NW-1:0] dsh;
	logic [NW:0]   diff [3];

	assign dsh = NW'(den_i) << SHIFT;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c] = {1'b0, rem_i[c]} - {1'b0, dsh};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			neg_o <= neg_i;
			for (int c = 0; c < 3; c++) begin
				if (!diff[c][NW]) begin
					rem_o[c] <= diff[c][NW-1:0];
					quo_o[c] <= quo_i[c] | (QB'(1) << SHIFT);
				end else begin
					rem_o[c] <= rem_i[c];
					quo_o[c] <= quo_i[c];
				end
			end
		end
	end

endmodule

`default_nettype wire

### sv/qrv_round_sat.sv
// ----------------------------------------------------------------------------
// qrv_round_sat
// Output stage: clamps the rounded quotients, applies signs, sets status.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_round_sat #(
	parameter int VW = 16,
	parameter int QB = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  qrv_pkg::ctrl_t        ctrl_i,
	input  logic [2:0][QB-1:0]    quo_i,
	input  logic [2:0]            neg_i,
	output logic                  vld_o,
	output logic [2:0][VW-1:0]    res_o,
	output qrv_pkg::status_t      status_o
);
	import qrv_pkg::*;

	logic [QB-1:0] lim [3];
	logic [QB-1:0] mag [3];
	logic [2:0]    sat;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			lim[c] = (QB'(1) << (VW-1)) - (neg_i[c] ? QB'(0) : QB'(1));
			sat[c] = quo_i[c] > lim[c];
			mag[c] = sat[c] ? lim[c] : quo_i[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= ctrl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (ctrl_i.zero) begin
					res_o[c] <= '0;
				end else if (neg_i[c]) begin
					res_o[c] <= VW'(-mag[c]);
				end else begin
					res_o[c] <= mag[c][VW-1:0];
				end
			end
			if (ctrl_i.zero) begin
				status_o <= ST_ZERO;
			end else if (|sat) begin
				status_o <= ST_SAT;
			end else begin
				status_o <= ST_OK;
			end
		end
	end

endmodule

`default_nettype wire

### sv/quaternion_rotate_vector_core.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_core
// Rotates a vector by a quaternion that need not be normalized:
// v' = vec(q * (0,v) * conj(q)) / |q|^2, rounded to nearest with ties away
// from zero and saturated to the vector width.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Word contents
//   -------  --------------------  ---------------------------------------
//   input    in_valid / in_ready   vec_x, vec_y, vec_z, quat_w..quat_z
//   output   out_valid / out_ready out_x, out_y, out_z, status
//
// One word enters per cycle while the output is not stalled. Each word passes
// through the stages of products and sums, one restoring division step per
// quotient bit (VEC_WIDTH + 1 of them), and the output register.
// The whole pipeline advances on one enable, which is high whenever the output
// register is empty or is being taken, so a stall freezes every stage in place.
// Reset clears only the valid and zero control bits; the datapath registers carry no reset.
//
`default_nettype none

module quaternion_rotate_vector_core #(
	parameter int VEC_WIDTH  = qrv_pkg::QRV_VEC_WIDTH,
	parameter int QUAT_WIDTH = qrv_pkg::QRV_QUAT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VEC_WIDTH-1:0]  vec_x,
	input  logic signed [VEC_WIDTH-1:0]  vec_y,
	input  logic signed [VEC_WIDTH-1:0]  vec_z,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VEC_WIDTH-1:0]  out_x,
	output logic signed [VEC_WIDTH-1:0]  out_y,
	output logic signed [VEC_WIDTH-1:0]  out_z,
	output qrv_pkg::status_t             status
);
	import qrv_pkg::*;

	// The numerator of each component is bounded by |q|^2 * |v|, so it fits
	// in RW signed bits. The rounded division works on 2|r| + d over 2d, and
	// since the exact quotient never exceeds sqrt(3) times the largest vector
	// component, VEC_WIDTH + 1 quotient bits always hold it.
	localparam int RW = 2*QUAT_WIDTH + VEC_WIDTH + 3;
	localparam int NW = RW + 1;
	localparam int DW = 2*QUAT_WIDTH + 1;
	localparam int QB = VEC_WIDTH + 1;

	logic en;

	ctrl_t              ctrl_d [QB+1];
	logic [DW:0]        den_d  [QB+1];
	logic [2:0][NW-1:0] rem_d  [QB+1];
	logic [2:0][QB-1:0] quo_d  [QB+1];
	logic [2:0]         neg_d  [QB+1];

	logic [2:0][VEC_WIDTH-1:0] res;

	// Single pipeline enable: the output register is free or being drained.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	qrv_quat_mul #(
		.VW(VEC_WIDTH),
		.QW(QUAT_WIDTH),
		.RW(RW),
		.NW(NW),
		.DW(DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (in_valid),
		.vx_i   (vec_x),
		.vy_i   (vec_y),
		.vz_i   (vec_z),
		.qw_i   (quat_w),
		.qx_i   (quat_x),
		.qy_i   (quat_y),
		.qz_i   (quat_z),
		.ctrl_o (ctrl_d[0]),
		.num_o  (rem_d[0]),
		.neg_o  (neg_d[0]),
		.den_o  (den_d[0])
	);

	assign quo_d[0] = '0;

	// Quotient bits are produced most significant first, one per stage.
	for (genvar k = 0; k < QB; k++) begin : g_div
		qrv_div_step #(
			.NW(NW),
			.DW(DW),
			.QB(QB),
			.SHIFT(QB-1-k)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_i (ctrl_d[k]),
			.den_i  (den_d[k]),
			.rem_i  (rem_d[k]),
			.quo_i  (quo_d[k]),
			.neg_i  (neg_d[k]),
			.ctrl_o (ctrl_d[k+1]),
			.den_o  (den_d[k+1]),
			.rem_o  (rem_d[k+1]),
			.quo_o  (quo_d[k+1]),
			.neg_o  (neg_d[k+1])
		);
	end

	// The remainder and divisor of the last step are not needed further on.
	qrv_round_sat #(
		.VW(VEC_WIDTH),
		.QB(QB)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_i   (ctrl_d[QB]),
		.quo_i    (quo_d[QB]),
		.neg_i    (neg_d[QB]),
		.vld_o    (out_valid),
		.res_o    (res),
		.status_o (status)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];

endmodule

`default_nettype wire

### sv/qrv_checker.sv
// ----------------------------------------------------------------------------
// qrv_checker
// Port-level checks for the quaternion rotation core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_checker #(
	parameter int VEC_WIDTH  = qrv_pkg::QRV_VEC_WIDTH,
	parameter int QUAT_WIDTH = qrv_pkg::QRV_QUAT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [VEC_WIDTH-1:0]  vec_x,
	input  logic signed [VEC_WIDTH-1:0]  vec_y,
	input  logic signed [VEC_WIDTH-1:0]  vec_z,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic signed [VEC_WIDTH-1:0]  out_x,
	input  logic signed [VEC_WIDTH-1:0]  out_y,
	input  logic signed [VEC_WIDTH-1:0]  out_z,
	input  qrv_pkg::status_t             status
);
	import qrv_pkg::*;

	// A held result word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(status))
		else $error("held output word changed");

	// The input side only stalls while a result waits untaken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input stalled without output backpressure");

	// A zero quaternion yields the zero vector.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ZERO |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("zero quaternion gave nonzero vector");

	// Only the three defined status codes appear.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_SAT || status == ST_ZERO)
		else $error("undefined status code");

endmodule

bind quaternion_rotate_vector_core qrv_checker #(
	.VEC_WIDTH(VEC_WIDTH),
	.QUAT_WIDTH(QUAT_WIDTH)
) u_qrv_checker (.*);

`default_nettype wire
